### rtl/assert_macros.svh
// Assertion helpers shared by the RTL modules.
// Both expect clk and the active-low rst_n to be in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/scwfp_pkg.sv
`timescale 1ns / 1ps

package scwfp_pkg;

  // Frame layout
  localparam int DATA_BYTES = 10;
  localparam int CNT_W      = $clog2(DATA_BYTES + 1);
  localparam int DIGITS     = 5;
  localparam int TENTHS_IDX = 6;
  // Only bytes 0 through the tenths byte feed the decode; the rest are counted, not kept.
  localparam int KEEP_BYTES = TENTHS_IDX + 1;

  // Result widths
  localparam int WEIGHT_W = 14;
  localparam int SUM_W    = 23;

  // Front-to-back job queue; depth is a power of two so the pointers wrap on their own.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Characters
  localparam logic [7:0] CH_W    = 8'h77;
  localparam logic [7:0] CH_G    = 8'h67;
  localparam logic [7:0] CH_N    = 8'h6E;
  localparam logic [7:0] CH_T    = 8'h74;
  localparam logic [7:0] CH_ZERO = 8'h30;

  localparam logic signed [SUM_W-1:0] WEIGHT_LIMIT = SUM_W'(9999);
  localparam logic signed [SUM_W-1:0] MUL_D0       = SUM_W'(10000);
  localparam logic signed [SUM_W-1:0] MUL_D1       = SUM_W'(1000);
  localparam logic signed [SUM_W-1:0] MUL_D2       = SUM_W'(100);
  localparam logic signed [SUM_W-1:0] MUL_D3       = SUM_W'(10);

  typedef logic [7:0] byte_t;

  typedef struct packed {
    byte_t [DIGITS-1:0] digit;
    byte_t              tenths;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight_units;
    byte_t               tenths_char;
    logic                reading_valid;
    logic                buzz;
  } result_t;

  // Character minus '0', sign-extended to the sum width.
  function automatic logic signed [SUM_W-1:0] digit_val(input byte_t b);
    logic signed [8:0] d;
    d = signed'({1'b0, b}) - signed'({1'b0, CH_ZERO});
    return SUM_W'(d);
  endfunction

endpackage

### rtl/scwfp_if.sv
`timescale 1ns / 1ps

interface scwfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       byte_present;
  logic       locked;

  modport source (output valid, rx_byte, byte_present, locked, input ready);
  modport sink   (input valid, rx_byte, byte_present, locked, output ready);
endinterface

interface scwfp_out_if;
  import scwfp_pkg::*;
  logic                valid;
  logic                ready;
  logic [WEIGHT_W-1:0] weight_units;
  logic [7:0]          tenths_char;
  logic                reading_valid;
  logic                buzz;

  modport source (output valid, weight_units, tenths_char, reading_valid, buzz, input ready);
  modport sink   (input valid, weight_units, tenths_char, reading_valid, buzz, output ready);
endinterface

### rtl/scwfp_queue.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module scwfp_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  scwfp_pkg::push_t push,
  input  logic             pop,
  output scwfp_pkg::qstat_t qstat,
  output scwfp_pkg::job_t  head
);
  import scwfp_pkg::*;

  job_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;
  logic              do_push;
  logic              do_pop;

  assign qstat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign qstat.empty = (count_r == '0);
  assign do_push     = push.valid && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head        = slot_r[rd_ptr_r];

  always_comb begin
    unique case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + QCNT_W'(1);
      2'b01:   count_nxt = count_r - QCNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push.job;
    end
  end

  `ASSERT_ALWAYS(a_q_no_overflow, push.valid |-> !qstat.full, "job pushed into a full queue")
  `ASSERT_ALWAYS(a_q_count_bound, count_r <= QCNT_W'(QUEUE_DEPTH), "queue count out of range")

endmodule

### rtl/scwfp_front.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module scwfp_front (
  input  logic              clk,
  input  logic              rst_n,
  scwfp_in_if.sink          in_ch,
  input  scwfp_pkg::qstat_t qstat,
  output scwfp_pkg::push_t  push
);
  import scwfp_pkg::*;

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_TYPE = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;

  logic [1:0]                 phase_r, phase_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;
  byte_t [KEEP_BYTES-1:0]     data_r, data_nxt;
  logic                       pending_r, pending_nxt;
  logic                       fire;
  logic                       type_ok;

  assign in_ch.ready = !qstat.full;
  assign fire        = in_ch.valid && in_ch.ready;
  assign type_ok     = (in_ch.rx_byte == CH_G) || (in_ch.rx_byte == CH_N) ||
                       (in_ch.rx_byte == CH_W) || (in_ch.rx_byte == CH_T);

  // Take the byte, then release a pending frame unless locked.
  always_comb begin
    phase_nxt   = phase_r;
    count_nxt   = count_r;
    data_nxt    = data_r;
    pending_nxt = pending_r;
    if (in_ch.byte_present) begin
      unique case (phase_r)
        PH_TYPE: phase_nxt = type_ok ? PH_DATA : PH_HUNT;
        PH_DATA: begin
          if (pending_r) begin
            phase_nxt = PH_HUNT;
          end else if (count_r < CNT_W'(DATA_BYTES)) begin
            for (int i = 0; i < KEEP_BYTES; i++) begin
              if (count_r == CNT_W'(i)) begin
                data_nxt[i] = in_ch.rx_byte;
              end
            end
            count_nxt = count_r + CNT_W'(1);
          end else begin
            count_nxt   = '0;
            phase_nxt   = PH_HUNT;
            pending_nxt = 1'b1;
          end
        end
        default: phase_nxt = (in_ch.rx_byte == CH_W) ? PH_TYPE : PH_HUNT;
      endcase
    end

    push.valid = fire && pending_nxt && !in_ch.locked;
    for (int i = 0; i < DIGITS; i++) begin
      push.job.digit[i] = data_nxt[i];
    end
    push.job.tenths = data_nxt[TENTHS_IDX];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      count_r   <= '0;
      pending_r <= 1'b0;
      data_r    <= '0;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      count_r   <= count_nxt;
      pending_r <= pending_nxt && in_ch.locked;
      data_r    <= push.valid ? '0 : data_nxt;
    end
  end

  `ASSERT_NEXT(a_fe_unlock_clears, fire && !in_ch.locked, !pending_r, "frame still pending after unlocked transfer")
  `ASSERT_ALWAYS(a_fe_count_range, count_r <= CNT_W'(DATA_BYTES), "byte count past frame length")

endmodule

### rtl/scwfp_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module scwfp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  scwfp_pkg::qstat_t qstat,
  input  scwfp_pkg::job_t   head,
  output logic              pop,
  scwfp_out_if.source       out_ch
);
  import scwfp_pkg::*;

  logic                       adv;

  // Stage A: partial sums
  logic                       a_valid_r;
  logic signed [SUM_W-1:0]    a_hi_r;
  logic signed [SUM_W-1:0]    a_lo_r;
  byte_t                      a_tenths_r;

  // Stage B: full sum and range check
  logic signed [SUM_W-1:0]    sum;
  logic                       sum_ok;
  logic                       b_valid_r;
  logic                       b_ok_r;
  logic [WEIGHT_W-1:0]        b_weight_r;
  byte_t                      b_tenths_r;

  // Output register and last valid reading
  logic                       out_valid_r;
  result_t                    res_r, res_nxt;
  logic                       have_last_r, have_last_nxt;
  logic [WEIGHT_W-1:0]        last_weight_r, last_weight_nxt;
  byte_t                      last_tenths_r, last_tenths_nxt;
  logic                       buzz_r, buzz_nxt;
  logic                       changed;

  assign adv = !out_valid_r || out_ch.ready;
  assign pop = adv && !qstat.empty;

  assign sum    = a_hi_r + a_lo_r;
  assign sum_ok = !sum[SUM_W-1] && (sum != '0) && (sum < WEIGHT_LIMIT);

  always_comb begin
    have_last_nxt   = have_last_r;
    last_weight_nxt = last_weight_r;
    last_tenths_nxt = last_tenths_r;
    buzz_nxt        = buzz_r;
    changed         = !have_last_r || (b_weight_r != last_weight_r) ||
                      (b_tenths_r != last_tenths_r);
    if (b_ok_r) begin
      if (changed) begin
        buzz_nxt        = 1'b1;
        have_last_nxt   = 1'b1;
        last_weight_nxt = b_weight_r;
        last_tenths_nxt = b_tenths_r;
      end
    end else begin
      buzz_nxt      = 1'b0;
      have_last_nxt = 1'b0;
    end
    res_nxt.weight_units  = b_weight_r;
    res_nxt.tenths_char   = b_tenths_r;
    res_nxt.reading_valid = b_ok_r;
    res_nxt.buzz          = buzz_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r     <= 1'b0;
      b_valid_r     <= 1'b0;
      out_valid_r   <= 1'b0;
      have_last_r   <= 1'b0;
      buzz_r        <= 1'b0;
      last_weight_r <= '0;
      last_tenths_r <= '0;
    end else if (adv) begin
      a_valid_r   <= pop;
      b_valid_r   <= a_valid_r;
      out_valid_r <= b_valid_r;
      if (b_valid_r) begin
        have_last_r   <= have_last_nxt;
        last_weight_r <= last_weight_nxt;
        last_tenths_r <= last_tenths_nxt;
        buzz_r        <= buzz_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_hi_r     <= digit_val(head.digit[0]) * MUL_D0 + digit_val(head.digit[1]) * MUL_D1;
      a_lo_r     <= digit_val(head.digit[2]) * MUL_D2 + digit_val(head.digit[3]) * MUL_D3 +
                    digit_val(head.digit[4]);
      a_tenths_r <= head.tenths;
      b_ok_r     <= sum_ok;
      b_weight_r <= sum_ok ? sum[WEIGHT_W-1:0] : '0;
      b_tenths_r <= sum_ok ? a_tenths_r : '0;
      res_r      <= res_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.weight_units  = res_r.weight_units;
  assign out_ch.tenths_char   = res_r.tenths_char;
  assign out_ch.reading_valid = res_r.reading_valid;
  assign out_ch.buzz          = res_r.buzz;

  `ASSERT_ALWAYS(a_be_invalid_zero, (out_valid_r && !res_r.reading_valid) |-> (res_r.weight_units == '0 && res_r.tenths_char == '0), "invalid reading carries data")
  `ASSERT_ALWAYS(a_be_buzz_valid, (out_valid_r && res_r.buzz) |-> res_r.reading_valid, "buzz set on invalid reading")

endmodule

### rtl/scale_weight_frame_parser_unit.sv
`timescale 1ns / 1ps
// Channel   Dir  Payload                                          Transfer
// in_ch     in   rx_byte[8] byte_present[1] locked[1]             valid && ready
// out_ch    out  weight_units[14] tenths_char[8] reading_valid[1]  valid && ready
//                buzz[1]
//
// One input transfer per cycle, sustained; in_ch.ready drops only when the
// four-entry job queue between parser and decoder is full.
// A released frame passes the job queue, then the partial sums, the sum and
// range check and the output register before it shows on out_ch.
// rst_n (synchronous, active low) clears parser, queue, pipeline and last reading.
// A stall on out_ch freezes the decode; the parser runs on until the queue fills.

module scale_weight_frame_parser_unit (
  input logic         clk,
  input logic         rst_n,
  scwfp_in_if.sink    in_ch,
  scwfp_out_if.source out_ch
);
  import scwfp_pkg::*;

  push_t  push;   // released frame, front to queue
  qstat_t qstat;  // queue fill status
  job_t   head;   // oldest queued frame
  logic   pop;    // decoder takes the head

  // Front: hunt for the header, collect data bytes, hold a finished frame
  // while locked, and push it as a job when released.
  scwfp_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .qstat (qstat),
    .push  (push)
  );

  // Short queue: lets the parser run on while the result side stalls.
  scwfp_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .qstat (qstat),
    .head  (head)
  );

  // Back: digit sum in two stages, range check, compare with the last valid
  // reading to drive the sticky buzz flag, then hold the result for out_ch.
  scwfp_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .qstat  (qstat),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import scwfp_pkg::*;

  // Drop sender and receiver idling once this few items are left to send.
  localparam int QUIET_TAIL     = 120;
  // Random part stops once this many serial bytes are queued.
  localparam int RANDOM_BYTES   = 700;
  // Receiver hold-off that forces the job queue to fill and stall the input.
  localparam int PRESSURE_HOLD  = 400;
  localparam int PRESSURE_AFTER = 20;
  // Cycles to keep watching after the last expected reading has arrived.
  localparam int DRAIN_CYCLES   = 20;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_SP  = 8'h20;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_TYPE,
    PH_DATA
  } parse_phase_e;

  typedef struct packed {
    byte_t rx_byte;
    logic  byte_present;
    logic  locked;
  } serial_item_t;

  logic clk = 1'b0;
  logic rst_n;

  scwfp_in_if  in_ch ();
  scwfp_out_if out_ch ();

  scale_weight_frame_parser_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // Stimulus waiting to be offered, and readings the parser is owed.
  serial_item_t serial_feed [$];
  result_t      expected_readings [$];

  // Shadow copy of the parser and the last-reading memory.
  parse_phase_e prs_phase;
  int           byte_cnt;
  byte_t        frame_bytes [DATA_BYTES];
  logic         res_pending;
  logic         have_last;
  logic [WEIGHT_W-1:0] last_weight;
  byte_t        last_tenths;
  logic         buzz_flag;

  // Stimulus generator state.
  int    lock_left;
  int    bytes_queued;
  logic  have_prev;
  byte_t prev_data [DATA_BYTES];

  // Handshake bookkeeping.
  serial_item_t next_item;
  int src_gap;
  int sink_gap;
  int stall_left;
  logic pressure_done;

  // Run statistics.
  int mismatches;
  int bytes_taken;
  int polls_taken;
  int readings_seen;
  int valid_seen;
  int buzz_seen;

  //--------------------------------------------------------------------------
  // Predictor: take one transfer, advance the shadow parser, and queue the
  // reading it releases, if any.
  //--------------------------------------------------------------------------
  task automatic parse_serial_item(input serial_item_t it);
    int      weight_sum;
    result_t rd;
    if (it.byte_present) begin
      case (prs_phase)
        PH_TYPE: begin
          if (it.rx_byte == CH_G || it.rx_byte == CH_N ||
              it.rx_byte == CH_W || it.rx_byte == CH_T)
            prs_phase = PH_DATA;
          else
            prs_phase = PH_HUNT;
        end
        PH_DATA: begin
          // A new frame body while a reading is still held back is dropped.
          if (res_pending) begin
            prs_phase = PH_HUNT;
          end else if (byte_cnt < DATA_BYTES) begin
            frame_bytes[byte_cnt] = it.rx_byte;
            byte_cnt++;
          end else begin
            // Terminator: drop the byte and complete the frame.
            byte_cnt    = 0;
            prs_phase   = PH_HUNT;
            res_pending = 1'b1;
          end
        end
        default: begin
          if (it.rx_byte == CH_W)
            prs_phase = PH_TYPE;
          else
            prs_phase = PH_HUNT;
        end
      endcase
    end

    if (res_pending && !it.locked) begin
      res_pending = 1'b0;
      // Place-value sum of (char - '0'); non-digits go in signed as they are.
      weight_sum = 0;
      for (int i = 0; i < DIGITS; i++)
        weight_sum = weight_sum * 10 + (int'(frame_bytes[i]) - int'(CH_ZERO));

      if (weight_sum > 0 && weight_sum < int'(WEIGHT_LIMIT)) begin
        rd.weight_units  = WEIGHT_W'(weight_sum);
        rd.tenths_char   = frame_bytes[TENTHS_IDX];
        rd.reading_valid = 1'b1;
        if (!have_last || rd.weight_units != last_weight ||
            rd.tenths_char != last_tenths) begin
          buzz_flag   = 1'b1;
          have_last   = 1'b1;
          last_weight = rd.weight_units;
          last_tenths = rd.tenths_char;
        end
      end else begin
        // Out-of-range reading: report zero and forget the last value.
        rd.weight_units  = '0;
        rd.tenths_char   = '0;
        rd.reading_valid = 1'b0;
        buzz_flag        = 1'b0;
        have_last        = 1'b0;
      end
      rd.buzz = buzz_flag;
      foreach (frame_bytes[i]) frame_bytes[i] = '0;
      expected_readings.push_back(rd);
    end
  endtask

  //--------------------------------------------------------------------------
  // Stimulus building
  //--------------------------------------------------------------------------
  task automatic queue_item(input byte_t b, input logic present, input logic lock);
    serial_feed.push_back('{rx_byte: b, byte_present: present, locked: lock});
  endtask

  // Random-part byte: lock comes in runs, and polls slip in between bytes.
  task automatic queue_random_byte(input byte_t b);
    if (lock_left == 0 && $urandom_range(0, 29) == 0)
      lock_left = $urandom_range(1, 20);
    if ($urandom_range(0, 9) == 0)
      queue_item(byte_t'($urandom_range(0, 255)), 1'b0, lock_left != 0);
    queue_item(b, 1'b1, lock_left != 0);
    if (lock_left != 0)
      lock_left--;
    bytes_queued++;
  endtask

  // Directed frame: unlocked throughout except, optionally, the terminator.
  task automatic queue_test_frame(input byte_t kind, input string digits,
                                  input byte_t tenths, input logic hold_end);
    queue_item(CH_W, 1'b1, 1'b0);
    queue_item(kind, 1'b1, 1'b0);
    for (int i = 0; i < DATA_BYTES; i++)
      queue_item(i < DIGITS ? byte_t'(digits[i]) :
                 (i == TENTHS_IDX ? tenths : (i == DIGITS ? CH_DOT : CH_SP)),
                 1'b1, 1'b0);
    queue_item(CH_CR, 1'b1, hold_end);
  endtask

  task automatic queue_random_frame();
    byte_t data [DATA_BYTES];
    byte_t kinds [4];
    string pick;
    int    mode;
    kinds = '{CH_G, CH_N, CH_W, CH_T};
    mode  = $urandom_range(0, 9);
    if (mode < 4 && have_prev) begin
      // Repeat the last frame so equal readings occur; sometimes bump tenths.
      data = prev_data;
      if (mode == 3)
        data[TENTHS_IDX] = byte_t'($urandom_range(48, 57));
    end else begin
      foreach (data[i]) data[i] = byte_t'($urandom_range(0, 255));
      for (int i = 0; i < DIGITS; i++) data[i] = byte_t'($urandom_range(48, 57));
      data[TENTHS_IDX] = byte_t'($urandom_range(48, 57));
      // Leading '0' keeps most readings in range.
      if (mode < 8)
        data[0] = CH_ZERO;
      // Off-digit byte pushes the sum negative or far out of range.
      if (mode == 8)
        data[$urandom_range(0, DIGITS - 1)] = byte_t'($urandom_range(0, 255));
      // Range boundaries on both sides.
      if (mode == 9) begin
        case ($urandom_range(0, 3))
          0:       pick = "00000";
          1:       pick = "09999";
          2:       pick = "09998";
          default: pick = "00001";
        endcase
        for (int i = 0; i < DIGITS; i++) data[i] = byte_t'(pick[i]);
      end
    end
    prev_data = data;
    have_prev = 1'b1;

    queue_random_byte(CH_W);
    queue_random_byte(kinds[$urandom_range(0, 3)]);
    foreach (data[i]) queue_random_byte(data[i]);
    queue_random_byte(byte_t'($urandom_range(0, 255)));
  endtask

  //--------------------------------------------------------------------------
  // Sender: offer the next item once the current one has transferred.
  //--------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (src_gap > 0) begin
        src_gap--;
        in_ch.valid <= 1'b0;
      end else if (serial_feed.size() != 0) begin
        next_item = serial_feed.pop_front();
        in_ch.valid        <= 1'b1;
        in_ch.rx_byte      <= next_item.rx_byte;
        in_ch.byte_present <= next_item.byte_present;
        in_ch.locked       <= next_item.locked;
        // Open an idle burst after this item, except near the end.
        if (serial_feed.size() > QUIET_TAIL && $urandom_range(0, 6) == 0)
          src_gap = $urandom_range(1, 5);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Input monitor: every transfer feeds the predictor.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      parse_serial_item('{rx_byte: in_ch.rx_byte, byte_present: in_ch.byte_present,
                          locked: in_ch.locked});
      if (in_ch.byte_present)
        bytes_taken++;
      else
        polls_taken++;
    end
  end

  //--------------------------------------------------------------------------
  // Receiver: check each reading against the oldest expectation, then pick
  // the next ready value (long hold-off once, short bursts otherwise).
  //--------------------------------------------------------------------------
  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        readings_seen++;
        if (out_ch.reading_valid === 1'b1) valid_seen++;
        if (out_ch.buzz === 1'b1) buzz_seen++;
        if (expected_readings.size() == 0) begin
          $display("%0t ns: reading expected none, got weight %0d tenths %0d valid %0d buzz %0d",
                   $time, out_ch.weight_units, out_ch.tenths_char,
                   out_ch.reading_valid, out_ch.buzz);
          mismatches++;
        end else begin
          check_field("weight_units", 32'(expected_readings[0].weight_units),
                      32'(out_ch.weight_units));
          check_field("tenths_char", 32'(expected_readings[0].tenths_char),
                      32'(out_ch.tenths_char));
          check_field("reading_valid", 32'(expected_readings[0].reading_valid),
                      32'(out_ch.reading_valid));
          check_field("buzz", 32'(expected_readings[0].buzz), 32'(out_ch.buzz));
          void'(expected_readings.pop_front());
        end
      end

      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!pressure_done && readings_seen >= PRESSURE_AFTER) begin
        // Hold off long enough for the job queue to fill and stall the input.
        pressure_done = 1'b1;
        stall_left    = PRESSURE_HOLD - 1;
        out_ch.ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (serial_feed.size() > QUIET_TAIL && $urandom_range(0, 5) == 0)
          sink_gap = $urandom_range(1, 5);
      end
    end
  end

  //--------------------------------------------------------------------------
  // Main sequence: build all stimulus, reset, drain, report.
  //--------------------------------------------------------------------------
  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.rx_byte      = '0;
    in_ch.byte_present = 1'b0;
    in_ch.locked       = 1'b0;
    out_ch.ready       = 1'b0;

    prs_phase   = PH_HUNT;
    byte_cnt    = 0;
    foreach (frame_bytes[i]) frame_bytes[i] = '0;
    res_pending = 1'b0;
    have_last   = 1'b0;
    last_weight = '0;
    last_tenths = '0;
    buzz_flag   = 1'b0;

    lock_left     = 0;
    bytes_queued  = 0;
    have_prev     = 1'b0;
    src_gap       = 0;
    sink_gap      = 0;
    stall_left    = 0;
    pressure_done = 1'b0;
    mismatches    = 0;
    bytes_taken   = 0;
    polls_taken   = 0;
    readings_seen = 0;
    valid_seen    = 0;
    buzz_seen     = 0;

    // Byte extremes in the hunt state, a poll carrying junk, a bad type letter.
    queue_item(8'h00, 1'b1, 1'b0);
    queue_item(8'hFF, 1'b1, 1'b1);
    queue_item(8'hA5, 1'b0, 1'b0);
    queue_item(CH_W, 1'b1, 1'b0);
    queue_item(8'h78, 1'b1, 1'b0);
    // Good frame held back by lock on its terminator and on a poll after it.
    queue_test_frame(CH_G, "01234", 8'h35, 1'b1);
    queue_item(8'h00, 1'b0, 1'b1);
    // Header while the reading is pending: first body byte gets dropped.
    queue_item(CH_W, 1'b1, 1'b1);
    queue_item(CH_N, 1'b1, 1'b1);
    queue_item(8'h31, 1'b1, 1'b1);
    // Release the held reading with an unlocked poll.
    queue_item(8'h00, 1'b0, 1'b0);
    // Out-of-range reading clears buzz.
    queue_test_frame(CH_T, "99999", 8'h37, 1'b0);

    // Random part: mostly well-formed frames, some broken headers and noise.
    while (bytes_queued < RANDOM_BYTES) begin
      case ($urandom_range(0, 9))
        7: begin
          queue_random_byte(CH_W);
          queue_random_byte(byte_t'($urandom_range(0, 255)));
        end
        8, 9: begin
          repeat ($urandom_range(1, 6)) queue_random_byte(byte_t'($urandom_range(0, 255)));
        end
        default: queue_random_frame();
      endcase
    end
    // Unlocked polls flush any reading still held back.
    queue_item(8'h00, 1'b0, 1'b0);
    queue_item(8'h00, 1'b0, 1'b0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (serial_feed.size() != 0 || in_ch.valid) @(posedge clk);
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d serial bytes and %0d polls, including a %0d-cycle receiver hold-off.",
             bytes_taken, polls_taken, PRESSURE_HOLD);
    $display("Checked %0d readings: %0d in range, %0d with buzz set.",
             readings_seen, valid_seen, buzz_seen);
    if (mismatches == 0) begin
      $display("scale_weight_frame_parser_unit: match");
    end else begin
      $display("scale_weight_frame_parser_unit: mismatch");
    end
    $finish;
  end

  // Watchdog: stops a run that hangs; the limit covers about 1000 items plus
  // the hold-off and receiver bursts.
  initial begin
    #2_000_000;
    $display("Timeout with %0d readings still expected", expected_readings.size());
    $display("scale_weight_frame_parser_unit: mismatch");
    $finish;
  end

endmodule
